FILE: design/e2q_pkg.sv
// Shared types and constants for the Euler-angle to quaternion unit.
// Holds the Q30 word layout, the CORDIC gain and the arctangent table.
// No dependencies.
package e2q_pkg;

  // Q30 working word used through the CORDIC chain and the products
  localparam int QW        = 32;
  localparam int PROD_W    = 2 * QW;
  localparam int MAX_STEPS = 32;

  // Angle lanes carried side by side through every cell
  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // Output component slots
  localparam int COMPS  = 4;
  localparam int COMP_W = 0;
  localparam int COMP_X = 1;
  localparam int COMP_Y = 2;
  localparam int COMP_Z = 3;

  // Pi in Q30 and the CORDIC gain 0.607252935 in Q30
  localparam logic [63:0]   PI_Q30   = 64'd3373259426;
  localparam logic [QW-1:0] GAIN_Q30 = 32'h26DD3B6A;

  // Rounding constant for a Q60 product brought back to Q30
  localparam logic [PROD_W-1:0] ROUND_Q30 = 64'd536870912;

  // atan(2^-i) in Q30, truncated
  localparam logic [QW-1:0] ATAN_Q30 [MAX_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  // One lane of CORDIC state: cosine, sine and residual angle, all Q30
  typedef struct packed {
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic [QW-1:0] z;
  } e2q_rot_t;

endpackage

FILE: design/e2q_if.sv
// Valid/ready channel interfaces for the Euler-angle to quaternion unit.
// e2q_angle_if carries roll, pitch and yaw; e2q_quat_if carries w, x, y, z.
// No dependencies.
interface e2q_angle_if #(
  parameter int ANGLE_W = 19
) ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

interface e2q_quat_if #(
  parameter int OUT_W = 16
) ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] quat_w;
  logic signed [OUT_W-1:0] quat_x;
  logic signed [OUT_W-1:0] quat_y;
  logic signed [OUT_W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                  output ready);
endinterface

FILE: design/e2q_cordic_cell.sv
// One rotation-mode CORDIC step, applied to the roll, pitch and yaw lanes.
// Cells are chained; each holds one transaction and passes it on when the next frees.
// Depends on e2q_pkg.
module e2q_cordic_cell import e2q_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  e2q_rot_t [LANES-1:0] in_rot,
  output logic                 out_valid,
  input  logic                 out_ready,
  output e2q_rot_t [LANES-1:0] out_rot
);

  localparam logic [QW-1:0] ATAN = ATAN_Q30[STEP];

  logic                 valid_r;
  e2q_rot_t [LANES-1:0] rot_r;
  e2q_rot_t [LANES-1:0] rot_nxt;

  // Take a new transaction when empty or when the neighbour takes ours
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rot   = rot_r;

  // Rotate each lane towards zero residual angle, using the old x and y
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [QW-1:0] dx;
      logic signed [QW-1:0] dy;
      dx = $signed(in_rot[l].y) >>> STEP;
      dy = $signed(in_rot[l].x) >>> STEP;
      if (in_rot[l].z[QW-1]) begin
        rot_nxt[l].x = in_rot[l].x + dx;
        rot_nxt[l].y = in_rot[l].y - dy;
        rot_nxt[l].z = in_rot[l].z + ATAN;
      end else begin
        rot_nxt[l].x = in_rot[l].x - dx;
        rot_nxt[l].y = in_rot[l].y + dy;
        rot_nxt[l].z = in_rot[l].z - ATAN;
      end
    end
  end

  // Hold or advance the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rot_r <= rot_nxt;
    end
  end

endmodule

FILE: design/e2q_combine.sv
// Product and rounding pipeline: half-angle cosines and sines to quaternion w, x, y, z.
// Six stages: pair products, round, triple products, round, sum, output round and saturate.
// Depends on e2q_pkg and e2q_quat_if.
module e2q_combine import e2q_pkg::*; #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  e2q_rot_t [LANES-1:0] in_rot,
  e2q_quat_if.source           out_ch
);

  localparam int NSTAGE = 6;
  localparam int OUT_W  = OUT_FRAC_BITS + 1;
  localparam int SUM_W  = QW + 1;
  localparam int RND_W  = QW + 2;
  localparam int SH     = 30 - OUT_FRAC_BITS;
  localparam logic signed [RND_W-1:0] HALF    = (34'sd1 <<< SH) >>> 1;
  localparam logic signed [RND_W-1:0] OUT_HI  = (34'sd1 <<< OUT_FRAC_BITS) - 34'sd1;
  localparam logic signed [RND_W-1:0] OUT_LO  = -(34'sd1 <<< OUT_FRAC_BITS);

  // Stage handshake: a stage loads when empty or when its successor loads
  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    rdy[NSTAGE] = out_ch.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage A: roll-by-pitch pair products, yaw terms carried along
  logic [PROD_W-1:0] pcc_r, pss_r, psc_r, pcs_r;
  logic [QW-1:0]     cy_a_r, sy_a_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pcc_r  <= PROD_W'($signed(in_rot[LANE_ROLL].x)) * PROD_W'($signed(in_rot[LANE_PITCH].x));
      pss_r  <= PROD_W'($signed(in_rot[LANE_ROLL].y)) * PROD_W'($signed(in_rot[LANE_PITCH].y));
      psc_r  <= PROD_W'($signed(in_rot[LANE_ROLL].y)) * PROD_W'($signed(in_rot[LANE_PITCH].x));
      pcs_r  <= PROD_W'($signed(in_rot[LANE_ROLL].x)) * PROD_W'($signed(in_rot[LANE_PITCH].y));
      cy_a_r <= in_rot[LANE_YAW].x;
      sy_a_r <= in_rot[LANE_YAW].y;
    end
  end

  // Stage B: round pair products back to Q30
  logic [QW-1:0] rcc_r, rss_r, rsc_r, rcs_r;
  logic [QW-1:0] cy_b_r, sy_b_r;
  logic [PROD_W-1:0] rcc_nxt, rss_nxt, rsc_nxt, rcs_nxt;

  always_comb begin
    rcc_nxt = $signed(pcc_r + ROUND_Q30) >>> 30;
    rss_nxt = $signed(pss_r + ROUND_Q30) >>> 30;
    rsc_nxt = $signed(psc_r + ROUND_Q30) >>> 30;
    rcs_nxt = $signed(pcs_r + ROUND_Q30) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      rcc_r  <= rcc_nxt[QW-1:0];
      rss_r  <= rss_nxt[QW-1:0];
      rsc_r  <= rsc_nxt[QW-1:0];
      rcs_r  <= rcs_nxt[QW-1:0];
      cy_b_r <= cy_a_r;
      sy_b_r <= sy_a_r;
    end
  end

  // Stage C: the eight triple products, two per component
  logic [2*COMPS-1:0][PROD_W-1:0] tprod_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      tprod_r[2*COMP_W]   <= PROD_W'($signed(rcc_r)) * PROD_W'($signed(cy_b_r));
      tprod_r[2*COMP_W+1] <= PROD_W'($signed(rss_r)) * PROD_W'($signed(sy_b_r));
      tprod_r[2*COMP_X]   <= PROD_W'($signed(rsc_r)) * PROD_W'($signed(cy_b_r));
      tprod_r[2*COMP_X+1] <= PROD_W'($signed(rcs_r)) * PROD_W'($signed(sy_b_r));
      tprod_r[2*COMP_Y]   <= PROD_W'($signed(rcs_r)) * PROD_W'($signed(cy_b_r));
      tprod_r[2*COMP_Y+1] <= PROD_W'($signed(rsc_r)) * PROD_W'($signed(sy_b_r));
      tprod_r[2*COMP_Z]   <= PROD_W'($signed(rcc_r)) * PROD_W'($signed(sy_b_r));
      tprod_r[2*COMP_Z+1] <= PROD_W'($signed(rss_r)) * PROD_W'($signed(cy_b_r));
    end
  end

  // Stage D: round triple products to Q30
  logic [2*COMPS-1:0][QW-1:0]     tq_r;
  logic [2*COMPS-1:0][PROD_W-1:0] tq_nxt;

  always_comb begin
    for (int t = 0; t < 2 * COMPS; t++) begin
      tq_nxt[t] = $signed(tprod_r[t] + ROUND_Q30) >>> 30;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int t = 0; t < 2 * COMPS; t++) begin
        tq_r[t] <= tq_nxt[t][QW-1:0];
      end
    end
  end

  // Stage E: sum for w and y, difference for x and z
  logic [COMPS-1:0][SUM_W-1:0] sum_r;
  logic [COMPS-1:0][SUM_W-1:0] sum_nxt;

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      if (c == COMP_W || c == COMP_Y) begin
        sum_nxt[c] = {tq_r[2*c][QW-1], tq_r[2*c]} + {tq_r[2*c+1][QW-1], tq_r[2*c+1]};
      end else begin
        sum_nxt[c] = {tq_r[2*c][QW-1], tq_r[2*c]} - {tq_r[2*c+1][QW-1], tq_r[2*c+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage F: round to the output format and saturate
  logic [COMPS-1:0][OUT_W-1:0] quat_r;
  logic [COMPS-1:0][OUT_W-1:0] quat_nxt;

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      logic signed [RND_W-1:0] biased;
      logic signed [RND_W-1:0] rnd;
      biased = $signed({sum_r[c][SUM_W-1], sum_r[c]}) + HALF;
      rnd    = biased >>> SH;
      if (rnd > OUT_HI) begin
        quat_nxt[c] = OUT_HI[OUT_W-1:0];
      end else if (rnd < OUT_LO) begin
        quat_nxt[c] = OUT_LO[OUT_W-1:0];
      end else begin
        quat_nxt[c] = rnd[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      quat_r <= quat_nxt;
    end
  end

  assign out_ch.valid  = valid_r[NSTAGE-1];
  assign out_ch.quat_w = quat_r[COMP_W];
  assign out_ch.quat_x = quat_r[COMP_X];
  assign out_ch.quat_y = quat_r[COMP_Y];
  assign out_ch.quat_z = quat_r[COMP_Z];

endmodule

FILE: design/euler_to_quaternion_unit.sv
// Euler angles (ZYX) to rotation quaternion, fully pipelined.
// Stages: an input clamp stage, one CORDIC cell per step, then six product and rounding
// stages.
// Throughput: one transaction per cycle; each stage stalls only when it and all later
// stages are full. Reset (rst_n low, synchronous) clears the stage valid flags only.
// Depends on e2q_pkg, e2q_if, e2q_cordic_cell and e2q_combine.
module euler_to_quaternion_unit import e2q_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 15,
  parameter int TRIG_STEPS      = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  e2q_angle_if.sink    in_ch,
  e2q_quat_if.source   out_ch
);

  localparam int ANGLE_W    = ANGLE_FRAC_BITS + 3;
  localparam int STEPS      = (TRIG_STEPS > MAX_STEPS) ? MAX_STEPS : TRIG_STEPS;
  localparam int Z_SHIFT    = 29 - ANGLE_FRAC_BITS;
  localparam int PIPE_DEPTH = 1 + STEPS + 6;
  localparam logic [63:0] PI_WIDE =
    (PI_Q30 + (64'd1 << Z_SHIFT)) >> (30 - ANGLE_FRAC_BITS);
  localparam logic signed [QW-1:0] PI_Q  = PI_WIDE[QW-1:0];
  localparam logic signed [QW-1:0] NPI_Q = -PI_Q;

  // Chain links: entry k feeds CORDIC cell k
  logic                 link_valid [STEPS+1];
  logic                 link_ready [STEPS+1];
  e2q_rot_t [LANES-1:0] link_rot   [STEPS+1];

  // Input stage: clamp to plus or minus pi, move the half angle into Q30
  logic                      stage0_valid_r;
  e2q_rot_t [LANES-1:0]      stage0_rot_r;
  e2q_rot_t [LANES-1:0]      stage0_rot_nxt;
  logic [LANES-1:0][ANGLE_W-1:0] angle_raw;

  assign angle_raw[LANE_ROLL]  = in_ch.roll_angle;
  assign angle_raw[LANE_PITCH] = in_ch.pitch_angle;
  assign angle_raw[LANE_YAW]   = in_ch.yaw_angle;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [QW-1:0] ang;
      logic signed [QW-1:0] clamped;
      ang = {{(QW - ANGLE_W){angle_raw[l][ANGLE_W-1]}}, angle_raw[l]};
      if (ang > PI_Q) begin
        clamped = PI_Q;
      end else if (ang < NPI_Q) begin
        clamped = NPI_Q;
      end else begin
        clamped = ang;
      end
      stage0_rot_nxt[l].x = GAIN_Q30;
      stage0_rot_nxt[l].y = '0;
      stage0_rot_nxt[l].z = clamped <<< Z_SHIFT;
    end
  end

  assign in_ch.ready = !stage0_valid_r || link_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      stage0_rot_r <= stage0_rot_nxt;
    end
  end

  assign link_valid[0] = stage0_valid_r;
  assign link_rot[0]   = stage0_rot_r;

  // Row of CORDIC cells, one step each
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    e2q_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_rot    (link_rot[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_rot   (link_rot[i+1])
    );
  end

  // Products, rounding and saturation
  e2q_combine #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (link_valid[STEPS]),
    .in_ready (link_ready[STEPS]),
    .in_rot   (link_rot[STEPS]),
    .out_ch   (out_ch)
  );

endmodule

FILE: design/e2q_checker.sv
// Port-level checks for euler_to_quaternion_unit, bound to the top level.
// Tracks transactions in flight against the pipeline depth.
// Depends on euler_to_quaternion_unit and e2q_if.
module e2q_checker #(
  parameter int OUT_W = 16,
  parameter int DEPTH = 23
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] quat_w,
  input logic [OUT_W-1:0] quat_x,
  input logic [OUT_W-1:0] quat_y,
  input logic [OUT_W-1:0] quat_z
);

  localparam int CW = $clog2(DEPTH + 2) + 1;

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions accepted but not yet delivered
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_free_flow : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the output side drains");

  a_depth : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH[CW-1:0])
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (occ_r != '0))
    else $error("result offered with nothing in flight");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({quat_w, quat_x, quat_y, quat_z})))
    else $error("stalled result dropped or changed");

endmodule

bind euler_to_quaternion_unit e2q_checker #(
  .OUT_W (OUT_FRAC_BITS + 1),
  .DEPTH (PIPE_DEPTH)
) u_e2q_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .quat_w    (out_ch.quat_w),
  .quat_x    (out_ch.quat_x),
  .quat_y    (out_ch.quat_y),
  .quat_z    (out_ch.quat_z)
);
